/* hdl/lpm_pkg.sv */
// shared types, constants and codes of the linear probe multimap
`default_nettype none
package lpm_pkg;

  // fixed field widths of the channels
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 10;

  // configuration port
  localparam int unsigned CFG_W         = 4;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned PADDR_W       = 2;
  localparam int unsigned BLOCKS_RESET  = 8;
  localparam logic [PADDR_W-1:0] ADDR_BLOCKS = '0;

  // hash reduction: remainder bits resolved per cycle
  localparam int unsigned MOD_STEP = 8;

  // default sizes
  localparam int unsigned MAX_BLOCKS_DEF  = 8;
  localparam int unsigned BLOCK_SLOTS_DEF = 64;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned MAX_MATCHES_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_MANY  = 3'd4
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [HASH_W-1:0]         hash;
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [FIELD_W-1:0] found_value;
    logic                      last;
    logic [COUNT_W-1:0]        entry_count;
  } out_t;

endpackage
`default_nettype wire

/* hdl/lpm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module lpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic [AW-1:0]        raddr_i,
  output      logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/lpm_mod.sv */
// multi-cycle remainder of the hash by a small divisor
`default_nettype none
module lpm_mod import lpm_pkg::*; #(
  parameter int unsigned DW = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [HASH_W-1:0] dividend_i,
  input  wire logic [DW-1:0]     divisor_i,
  output      logic              done_o,
  output      logic [DW-1:0]     rem_o
);
  localparam int unsigned CYCLES = HASH_W / MOD_STEP;
  localparam int unsigned CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [HASH_W-1:0] dvd_q, dvd_d;
  logic [DW-1:0]     rem_q, rem_d;

  // restoring remainder, MOD_STEP bits per cycle, msb first
  always_comb begin
    logic [DW:0]       r;
    logic [HASH_W-1:0] d;
    r = {1'b0, rem_q};
    d = dvd_q;
    for (int i = 0; i < MOD_STEP; i++) begin
      r = {r[DW-1:0], d[HASH_W-1]};
      d = d << 1;
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
      end
    end
    rem_d = r[DW-1:0];
    dvd_d = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

/* hdl/linear_probe_multimap_unit.sv */
// top level: hash multimap with linear probing and tombstones over one slot ram
// steps: hash reduction (S_MOD), start read (S_START), probe on the slot ram read port
// (S_SCAN), then S_ONE per insert/remove result or S_EMIT_RD and S_EMIT per lookup result
// throughput: one item at a time; a new item is taken once the previous one has
// handed its last result to the output register
// reset: asynchronous; afterwards a clearing pass writes every slot, one a cycle
// (all MAX_BLOCKS*BLOCK_SLOTS slots, 512 by default), with input stalled
`default_nettype none
module linear_probe_multimap_unit import lpm_pkg::*; #(
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_SLOTS = BLOCK_SLOTS_DEF,
  parameter int unsigned KEY_BITS    = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned MAX_MATCHES = MAX_MATCHES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_t                in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_t               out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);
  localparam int unsigned TOTAL  = MAX_BLOCKS * BLOCK_SLOTS;
  localparam int unsigned POS_W  = $clog2(TOTAL);
  localparam int unsigned SPAN_W = $clog2(TOTAL + 1);
  localparam int unsigned BLK_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SLOT_W = $clog2(BLOCK_SLOTS + 1);
  localparam int unsigned CNT_W  = $clog2(TOTAL + 1);
  localparam int unsigned HIT_AW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int unsigned NHIT_W = $clog2(MAX_MATCHES + 2);
  localparam int unsigned ENT_W  = 2 + KEY_BITS + VALUE_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_START, S_SCAN, S_ONE, S_EMIT_RD, S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [POS_W-1:0]    clr_q, clr_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [POS_W-1:0]    cur_q, cur_d;
  logic [SPAN_W-1:0]   span_q, span_d;
  logic [SPAN_W-1:0]   steps_q, steps_d;
  logic                free_found_q, free_found_d;
  logic [POS_W-1:0]    free_pos_q, free_pos_d;
  logic [NHIT_W-1:0]   nhits_q, nhits_d;
  logic [HIT_AW-1:0]   k_q, k_d;
  status_e             status_q, status_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic [CFG_W-1:0]    blocks_q;

  // configuration
  logic [BLK_W-1:0] nb;
  always_comb begin
    if (blocks_q == '0) begin
      nb = BLK_W'(1);
    end else if (int'(blocks_q) > int'(MAX_BLOCKS)) begin
      nb = BLK_W'(MAX_BLOCKS);
    end else begin
      nb = BLK_W'(blocks_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= CFG_W'(BLOCKS_RESET);
    end else if (psel && penable && pwrite) begin
      blocks_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BLOCKS) ? PDATA_W'(blocks_q) : '0;

  // hash reduction
  logic              mod_start;
  logic              blk_done, slot_done;
  logic [BLK_W-1:0]  blk_rem;
  logic [SLOT_W-1:0] slot_rem;

  lpm_mod #(.DW(BLK_W)) u_blk_mod (
    .clk_i, .rst_ni,
    .start_i(mod_start), .dividend_i(in_data_i.hash), .divisor_i(nb),
    .done_o(blk_done), .rem_o(blk_rem)
  );

  lpm_mod #(.DW(SLOT_W)) u_slot_mod (
    .clk_i, .rst_ni,
    .start_i(mod_start), .dividend_i(in_data_i.hash), .divisor_i(SLOT_W'(BLOCK_SLOTS)),
    .done_o(slot_done), .rem_o(slot_rem)
  );

  // slot ram: {occupied, live, key, value}
  logic             ram_we;
  logic [POS_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  lpm_ram #(.WIDTH(ENT_W), .DEPTH(TOTAL)) u_slot_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // lookup hit buffer
  logic                  hit_we;
  logic [VALUE_BITS-1:0] hit_rdata;

  lpm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_MATCHES)) u_hit_ram (
    .clk_i, .we_i(hit_we), .waddr_i(nhits_q[HIT_AW-1:0]), .wdata_i(ram_rdata[VALUE_BITS-1:0]),
    .raddr_i(k_q), .rdata_o(hit_rdata)
  );

  logic                  ent_occ, ent_live, hit_key, hit_pair, last_step, out_free;
  logic [KEY_BITS-1:0]   ent_key;
  logic [VALUE_BITS-1:0] ent_val;
  logic [SPAN_W-1:0]     start_wide, span_now;
  logic [POS_W-1:0]      cur_next, take_pos;
  logic                  over;
  logic [NHIT_W-1:0]     n_out;

  assign ent_occ   = ram_rdata[ENT_W-1];
  assign ent_live  = ram_rdata[ENT_W-2];
  assign ent_key   = ram_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign ent_val   = ram_rdata[VALUE_BITS-1:0];
  assign hit_key   = ent_live && (ent_key == key_q);
  assign hit_pair  = hit_key && (ent_val == val_q);
  assign last_step = (steps_q + SPAN_W'(1)) == span_q;
  assign cur_next  = ((SPAN_W'(cur_q) + SPAN_W'(1)) == span_q) ? '0 : cur_q + POS_W'(1);
  assign take_pos  = free_found_q ? free_pos_q : cur_q;
  assign start_wide = SPAN_W'(blk_rem) * SPAN_W'(BLOCK_SLOTS) + SPAN_W'(slot_rem);
  assign span_now  = SPAN_W'(nb) * SPAN_W'(BLOCK_SLOTS);
  assign over      = nhits_q > NHIT_W'(MAX_MATCHES);
  assign n_out     = over ? NHIT_W'(MAX_MATCHES) : nhits_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    mode_d       = mode_q;
    key_d        = key_q;
    val_d        = val_q;
    cur_d        = cur_q;
    span_d       = span_q;
    steps_d      = steps_q;
    free_found_d = free_found_q;
    free_pos_d   = free_pos_q;
    nhits_d      = nhits_q;
    k_d          = k_q;
    status_d     = status_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = '0;
    ram_raddr    = cur_q;
    hit_we       = 1'b0;
    mod_start    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + POS_W'(1);
        if (clr_q == POS_W'(TOTAL - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d    = in_data_i.mode;
          key_d     = KEY_BITS'($unsigned(in_data_i.key));
          val_d     = VALUE_BITS'($unsigned(in_data_i.value));
          mod_start = 1'b1;
          if (in_data_i.mode == MODE_LOOKUP || in_data_i.mode == MODE_INSERT ||
              in_data_i.mode == MODE_REMOVE) begin
            state_d = S_MOD;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_ONE;
          end
        end
      end
      S_MOD: begin
        if (blk_done && slot_done) begin
          state_d = S_START;
        end
      end
      S_START: begin
        ram_raddr    = POS_W'(start_wide);
        cur_d        = POS_W'(start_wide);
        span_d       = span_now;
        steps_d      = '0;
        free_found_d = 1'b0;
        nhits_d      = '0;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        // read of the following slot goes out while this one is judged
        ram_raddr = cur_next;
        cur_d     = cur_next;
        steps_d   = steps_q + SPAN_W'(1);
        case (mode_q)
          MODE_LOOKUP: begin
            if (ent_occ && hit_key) begin
              if (nhits_q < NHIT_W'(MAX_MATCHES)) begin
                hit_we = 1'b1;
              end
              if (nhits_q <= NHIT_W'(MAX_MATCHES)) begin
                nhits_d = nhits_q + NHIT_W'(1);
              end
            end
            if (!ent_occ || last_step) begin
              k_d     = '0;
              state_d = S_EMIT_RD;
            end
          end
          MODE_INSERT: begin
            if (!free_found_q && !ent_live) begin
              free_found_d = 1'b1;
              free_pos_d   = cur_q;
            end
            if (ent_occ && hit_pair) begin
              status_d = ST_PRESENT;
              state_d  = S_ONE;
            end else if (!ent_occ || last_step) begin
              // a tombstone met earlier is reused before this slot
              if (free_found_q || !ent_live) begin
                ram_we    = 1'b1;
                ram_waddr = take_pos;
                ram_wdata = {2'b11, key_q, val_q};
                count_d   = count_q + CNT_W'(1);
                status_d  = ST_OK;
              end else begin
                status_d = ST_FULL;
              end
              state_d = S_ONE;
            end
          end
          MODE_REMOVE: begin
            if (!ent_occ) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_ONE;
            end else if (hit_pair) begin
              ram_we    = 1'b1;
              ram_waddr = cur_q;
              ram_wdata = {2'b10, ent_key, ent_val};
              if (count_q != '0) begin
                count_d = count_q - CNT_W'(1);
              end
              status_d = ST_OK;
              state_d  = S_ONE;
            end else if (last_step) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_ONE;
            end
          end
          default: begin
            status_d = ST_NOT_FOUND;
            state_d  = S_ONE;
          end
        endcase
      end
      S_ONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.status          = status_q;
          out_d.found_value     = '0;
          out_d.last            = 1'b1;
          out_d.entry_count     = COUNT_W'(count_q);
          state_d               = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.entry_count = COUNT_W'(count_q);
          out_d.found_value = '0;
          out_d.last        = 1'b1;
          if (nhits_q == '0) begin
            out_d.status = ST_NOT_FOUND;
            state_d      = S_IDLE;
          end else if (over && (NHIT_W'(k_q) == NHIT_W'(MAX_MATCHES - 1))) begin
            out_d.status = ST_TOO_MANY;
            state_d      = S_IDLE;
          end else begin
            out_d.status      = ST_OK;
            out_d.found_value = $signed(FIELD_W'(hit_rdata));
            out_d.last        = (NHIT_W'(k_q) + NHIT_W'(1)) == n_out;
            if ((NHIT_W'(k_q) + NHIT_W'(1)) == n_out) begin
              state_d = S_IDLE;
            end else begin
              k_d     = k_q + HIT_AW'(1);
              state_d = S_EMIT_RD;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      nhits_q     <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      nhits_q     <= nhits_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    val_q        <= val_d;
    cur_q        <= cur_d;
    span_q       <= span_d;
    steps_q      <= steps_d;
    free_found_q <= free_found_d;
    free_pos_q   <= free_pos_d;
    status_q     <= status_d;
    out_q        <= out_d;
  end

endmodule
`default_nettype wire

/* hdl/lpm_checker.sv */
// port-level checks of the multimap, bound to the top level
`default_nettype none
module lpm_checker import lpm_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire out_t               out_data_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one item at a time: a transfer in closes the input for the next cycle
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // every status other than ok ends its item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.last)
    else $error("non-ok result not marked last");

  // only lookup hits carry a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.found_value == '0))
    else $error("non-ok result carries a value");

endmodule

bind linear_probe_multimap_unit lpm_checker u_lpm_checker (.*);
`default_nettype wire

/* tb/linear_probe_multimap_unit_test.sv */
// testbench of the linear probe multimap: directed table, random phases, predictor check
`default_nettype none
module linear_probe_multimap_unit_test;
  import lpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOTS     = MAX_BLOCKS_DEF * BLOCK_SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_t  in_data_i;
  out_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  linear_probe_multimap_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mirror of the table
  logic              slot_occ  [NSLOTS];
  logic              slot_lv   [NSLOTS];
  logic [FIELD_W-1:0] slot_key [NSLOTS];
  logic [FIELD_W-1:0] slot_val [NSLOTS];
  int unsigned       live_n;
  logic [CFG_W-1:0]  blocks_cfg;

  out_t        pending_results[$];
  int unsigned err_count;
  int unsigned cycle_n;
  bit          calm;
  bit          hold_req;
  int unsigned hold_left;

  function automatic out_t make_result(status_e st, logic [FIELD_W-1:0] v, logic lst);
    out_t r;
    r.status      = st;
    r.found_value = v;
    r.last        = lst;
    r.entry_count = live_n[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void queue_result(out_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic int unsigned next_slot(int unsigned p, int unsigned span);
    return (p + 1 == span) ? 0 : p + 1;
  endfunction

  // works out the results of one accepted operation and updates the mirror
  function automatic void predict_operation(in_t it);
    int unsigned nb, span, start, pos, nhits;
    logic [FIELD_W-1:0] hits[$];
    bit done;
    nb = (blocks_cfg == 0) ? 1 : (blocks_cfg > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : blocks_cfg;
    span = nb * BLOCK_SLOTS_DEF;
    start = (it.hash % nb) * BLOCK_SLOTS_DEF + it.hash % BLOCK_SLOTS_DEF;
    done = 0;
    nhits = 0;
    pos = start;
    case (it.mode)
      MODE_LOOKUP: begin
        for (int s = 0; s < span && slot_occ[pos]; s++) begin
          if (slot_lv[pos] && slot_key[pos] == it.key) begin
            if (nhits < MAX_MATCHES_DEF) hits = {hits, slot_val[pos]};
            nhits++;
          end
          pos = next_slot(pos, span);
        end
        if (nhits == 0) begin
          queue_result(make_result(ST_NOT_FOUND, '0, 1'b1));
        end else if (nhits > MAX_MATCHES_DEF) begin
          for (int k = 0; k < MAX_MATCHES_DEF - 1; k++)
            queue_result(make_result(ST_OK, hits[k], 1'b0));
          queue_result(make_result(ST_TOO_MANY, '0, 1'b1));
        end else begin
          foreach (hits[k])
            queue_result(make_result(ST_OK, hits[k], k + 1 == nhits));
        end
      end
      MODE_INSERT: begin
        for (int s = 0; s < span && slot_occ[pos] && !done; s++) begin
          if (slot_lv[pos] && slot_key[pos] == it.key && slot_val[pos] == it.value) begin
            queue_result(make_result(ST_PRESENT, '0, 1'b1));
            done = 1;
          end
          pos = next_slot(pos, span);
        end
        pos = start;
        for (int s = 0; s < span && !done; s++) begin
          if (!slot_lv[pos]) begin
            slot_key[pos] = it.key;
            slot_val[pos] = it.value;
            slot_occ[pos] = 1'b1;
            slot_lv[pos]  = 1'b1;
            live_n++;
            queue_result(make_result(ST_OK, '0, 1'b1));
            done = 1;
          end
          pos = next_slot(pos, span);
        end
        if (!done) queue_result(make_result(ST_FULL, '0, 1'b1));
      end
      MODE_REMOVE: begin
        for (int s = 0; s < span && slot_occ[pos] && !done; s++) begin
          if (slot_lv[pos] && slot_key[pos] == it.key && slot_val[pos] == it.value) begin
            slot_lv[pos] = 1'b0;
            if (live_n > 0) live_n--;
            queue_result(make_result(ST_OK, '0, 1'b1));
            done = 1;
          end
          pos = next_slot(pos, span);
        end
        if (!done) queue_result(make_result(ST_NOT_FOUND, '0, 1'b1));
      end
      default: queue_result(make_result(ST_NOT_FOUND, '0, 1'b1));
    endcase
  endfunction

  // offers one operation, with a random gap first, and waits for the transfer
  task automatic send_operation(in_t it);
    if (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_operation(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_blocks(logic [CFG_W-1:0] nb);
    drain_results();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_BLOCKS; pwdata <= PDATA_W'(nb);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    blocks_cfg = nb;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CFG_W-1:0] !== nb) begin
      $error("blocks_in_use readback: expected %0d actual %0d", nb, prdata[CFG_W-1:0]);
      err_count++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // result side: random stall, long hold on request, field checks
  always @(posedge clk_i) begin
    out_t want;
    cycle_n <= cycle_n + 1;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_data_o.status);
          err_count++;
        end
        if (out_data_o.found_value !== want.found_value) begin
          $error("found_value: expected %0d actual %0d",
                 want.found_value, out_data_o.found_value);
          err_count++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_data_o.last);
          err_count++;
        end
        if (out_data_o.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d actual %0d",
                 want.entry_count, out_data_o.entry_count);
          err_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 37);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_n > CYCLE_LIMIT) begin
      $display("linear_probe_multimap_unit_test: errors");
      $finish;
    end
  end

  typedef struct {
    in_t              op;
    bit               typed;
    status_e          st;
    logic [COUNT_W-1:0] cnt;
  } table_row_t;

  localparam logic [FIELD_W-1:0] KMIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] KMAX = 32'h7fff_ffff;

  table_row_t directed[] = '{
    '{'{MODE_LOOKUP, 32'h0, 32'h0, 32'h0},           1, ST_NOT_FOUND, 10'd0},
    '{'{MODE_REMOVE, 32'h0, 32'h0, 32'h0},           1, ST_NOT_FOUND, 10'd0},
    '{'{2'd3, 32'hffff_ffff, KMAX, KMIN},            1, ST_NOT_FOUND, 10'd0},
    '{'{MODE_INSERT, 32'hffff_ffff, KMIN, KMAX},     1, ST_OK,        10'd1},
    '{'{MODE_INSERT, 32'hffff_ffff, KMIN, KMAX},     1, ST_PRESENT,   10'd1},
    '{'{MODE_INSERT, 32'h0, KMAX, KMIN},             1, ST_OK,        10'd2},
    '{'{MODE_LOOKUP, 32'hffff_ffff, KMIN, 32'h0},    0, ST_OK,        10'd0},
    '{'{MODE_INSERT, 32'hffff_ffff, KMIN, 32'h0},    1, ST_OK,        10'd3},
    '{'{MODE_LOOKUP, 32'hffff_ffff, KMIN, 32'h5},    0, ST_OK,        10'd0},
    '{'{MODE_REMOVE, 32'hffff_ffff, KMIN, KMAX},     1, ST_OK,        10'd2},
    '{'{MODE_LOOKUP, 32'hffff_ffff, KMIN, 32'h0},    0, ST_OK,        10'd0},
    '{'{MODE_INSERT, 32'hffff_ffff, KMIN, KMAX},     1, ST_OK,        10'd3},
    '{'{MODE_REMOVE, 32'h0, 32'h0, 32'h0},           1, ST_NOT_FOUND, 10'd3},
    '{'{MODE_LOOKUP, 32'h0, KMAX, 32'h0},            0, ST_OK,        10'd0}
  };

  logic [FIELD_W-1:0] key_pool[4], val_pool[4], hash_pool[4];

  function automatic in_t random_operation(int unsigned ins_pct);
    in_t it;
    int unsigned r, ki;
    r  = $urandom_range(99);
    ki = $urandom_range(3);
    it.mode  = (r < ins_pct) ? MODE_INSERT : (r < ins_pct + 25) ? MODE_LOOKUP :
               (r < 97) ? MODE_REMOVE : 2'd3;
    it.key   = ($urandom_range(9) == 0) ? $urandom : key_pool[ki];
    it.value = ($urandom_range(9) == 0) ? $urandom : val_pool[$urandom_range(3)];
    it.hash  = ($urandom_range(4) == 0) ? $urandom : hash_pool[ki];
    return it;
  endfunction

  logic [CFG_W-1:0] phase_blocks[] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    err_count = 0; cycle_n = 0; calm = 0; hold_req = 0; hold_left = 0;
    live_n = 0; blocks_cfg = CFG_W'(BLOCKS_RESET);
    foreach (slot_occ[i]) begin
      slot_occ[i] = 1'b0; slot_lv[i] = 1'b0; slot_key[i] = '0; slot_val[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_operation(directed[i].op);
      if (directed[i].typed) begin
        pending_results[pending_results.size() - 1] =
          '{directed[i].st, '0, 1'b1, directed[i].cnt};
      end
    end
    // overflow: seventeen values under one key, then a lookup
    for (int v = 0; v < 17; v++) send_operation('{MODE_INSERT, 32'h7, 32'h5, v});
    send_operation('{MODE_LOOKUP, 32'h7, 32'h5, 32'h0});
    // sender waits for every result before going on
    drain_results();

    foreach (phase_blocks[p]) begin
      set_blocks(phase_blocks[p]);
      foreach (key_pool[i]) begin
        key_pool[i] = $urandom; val_pool[i] = $urandom; hash_pool[i] = $urandom;
      end
      calm = (p == 3);
      if (p == 2) hold_req = 1'b1;
      // small tables fill up to reach the full status
      for (int n = 0; n < ((phase_blocks[p] <= 1) ? 80 : 60); n++)
        send_operation(random_operation((phase_blocks[p] <= 1) ? 65 : 40));
    end
    calm = 0;

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("linear_probe_multimap_unit_test: clean");
    end else begin
      $display("linear_probe_multimap_unit_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
